// File: hw/rtl/bmsrx_pkg.sv
// ----------------------------------------------------------------------------
// bmsrx_pkg
// Shared types and constants of the smart battery response frame receiver.
// ----------------------------------------------------------------------------
package bmsrx_pkg;

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] STOP_BYTE  = 8'h77;

  // frame verdict codes
  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_BAD_SUM  = 2'd1;
  localparam logic [1:0] RES_BAD_STOP = 2'd2;

  typedef struct packed {
    logic [7:0] device_status;
    logic [7:0] register_code;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [1:0] frame_result;
  } bmsrx_result_t;

endpackage

// File: hw/rtl/bmsrx_parser.sv
// ----------------------------------------------------------------------------
// bmsrx_parser
// Frame state machine: hunts for the start byte, walks the header, payload,
// checksum and stop byte, keeps the running sum and forms the result item.
// ----------------------------------------------------------------------------
module bmsrx_parser
  import bmsrx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          consume,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output bmsrx_result_t res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_STATUS  = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SUM_HI  = 3'd5;
  localparam logic [2:0] PH_SUM_LO  = 3'd6;
  localparam logic [2:0] PH_STOP    = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  checksum_high, checksum_high_next;
  logic        checksum_bad, checksum_bad_next;
  logic [7:0]  code_held, code_held_next;
  logic [7:0]  status_held, status_held_next;

  logic [15:0] sum_plus;
  logic [15:0] sum_want;
  logic [7:0]  count_inc;

  assign sum_plus  = running_sum + {8'd0, rx_byte};
  assign sum_want  = (~running_sum) + 16'd1;
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    checksum_high_next  = checksum_high;
    checksum_bad_next   = checksum_bad;
    code_held_next      = code_held;
    status_held_next    = status_held;
    res_valid           = 1'b0;
    res.device_status   = status_held;
    res.register_code   = code_held;
    res.payload_index   = 8'd0;
    res.payload_byte    = 8'd0;
    res.frame_end       = 1'b0;
    res.frame_result    = RES_OK;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          running_sum_next  = 16'd0;
          byte_count_next   = 8'd0;
          checksum_bad_next = 1'b0;
          phase_next        = PH_CODE;
        end
      end
      PH_CODE: begin
        code_held_next = rx_byte;
        phase_next     = PH_STATUS;
      end
      PH_STATUS: begin
        status_held_next = rx_byte;
        running_sum_next = sum_plus;
        phase_next       = PH_LENGTH;
      end
      PH_LENGTH: begin
        payload_length_next = rx_byte;
        running_sum_next    = sum_plus;
        byte_count_next     = 8'd0;
        phase_next          = (rx_byte == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next  = sum_plus;
        res_valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = byte_count;
        byte_count_next   = count_inc;
        if (count_inc == payload_length) begin
          phase_next = PH_SUM_HI;
        end
      end
      PH_SUM_HI: begin
        checksum_high_next = rx_byte;
        phase_next         = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        checksum_bad_next = ({checksum_high, rx_byte} != sum_want);
        phase_next        = PH_STOP;
      end
      PH_STOP: begin
        res_valid     = 1'b1;
        res.frame_end = 1'b1;
        // a bad stop byte outranks a bad checksum
        if (rx_byte != STOP_BYTE) begin
          res.frame_result = RES_BAD_STOP;
        end else if (checksum_bad) begin
          res.frame_result = RES_BAD_SUM;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      running_sum    <= 16'd0;
      payload_length <= 8'd0;
      byte_count     <= 8'd0;
      checksum_high  <= 8'd0;
      checksum_bad   <= 1'b0;
      code_held      <= 8'd0;
      status_held    <= 8'd0;
    end else if (consume) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      checksum_high  <= checksum_high_next;
      checksum_bad   <= checksum_bad_next;
      code_held      <= code_held_next;
      status_held    <= status_held_next;
    end
  end

endmodule

// File: hw/rtl/bmsrx_out_reg.sv
// ----------------------------------------------------------------------------
// bmsrx_out_reg
// Result register that holds an item until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmsrx_out_reg
  import bmsrx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          in_valid,
  input  bmsrx_result_t in_res,
  output logic          out_valid,
  output bmsrx_result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

// File: hw/rtl/bms_response_frame_receiver.sv
// ----------------------------------------------------------------------------
// bms_response_frame_receiver
// Parses smart battery response frames from a stream of received bytes.
//
// Input channel s_axis: one received serial byte per item.
// Output channel m_axis: one item per payload byte (byte, index, code,
// status) and one closing item per frame with tlast high and the verdict
// in tuser (0 ok, 1 checksum mismatch, 2 bad stop byte).
// Bytes outside a frame, header, checksum bytes produce no item.
// Throughput: one byte per cycle, sustained while m_axis is not stalled.
// Path: a byte taken from s_axis lands in the input register, is parsed
// from there and its item is registered in the output register on m_axis.
// A stalled m_axis holds its item; the input register still takes a byte
// while the result waits, after that s_axis_tready drops until the output
// moves on.
// Reset (rst, synchronous) empties both registers and returns the parser to
// hunting for the start byte with a cleared sum.
// ----------------------------------------------------------------------------
module bms_response_frame_receiver
  import bmsrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                      // [23:16] register_code, [31:24] device_status
  output logic        m_axis_tlast,   // frame_end
  output logic [1:0]  m_axis_tuser    // frame_result
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;
  logic          consume;
  logic          res_valid;
  bmsrx_result_t res;
  bmsrx_result_t out_res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign consume       = in_valid && advance;
  assign s_axis_tready = advance || !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  bmsrx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  bmsrx_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (consume && res_valid),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {out_res.device_status, out_res.register_code,
                         out_res.payload_index, out_res.payload_byte};
  assign m_axis_tlast = out_res.frame_end;
  assign m_axis_tuser = out_res.frame_result;

  // a held input byte must not be lost or changed while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input byte dropped during stall");

  // payload items carry no verdict
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == RES_OK)
    else $error("verdict on a payload item");

  // the closing item has zero byte and index
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[15:0] == 16'd0)
    else $error("nonzero data on frame end item");

  // verdict is one of the three defined codes
  a_res_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == RES_OK || m_axis_tuser == RES_BAD_SUM ||
                       m_axis_tuser == RES_BAD_STOP))
    else $error("undefined verdict code");

endmodule
